### design/rdq_pkg.sv
// Shared types and constants for the ring deque with overwrite.
package rdq_pkg;

   localparam int MODE_W     = 3;
   localparam int FIELD_W    = 32;
   localparam int OFFSET_W   = 8;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 9;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int CAPACITY_RESET = 256;

   localparam logic [CSR_ADDR_W-1:0] CSR_CAPACITY_ADDR = 3'd0;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_BACK  = 3'd0,
      MODE_PUSH_FRONT = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_READ_AT    = 3'd4,
      MODE_INSERT_AT  = 3'd5,
      MODE_CLEAR      = 3'd6
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_RANGE     = 2'd2,
      STATUS_OVERWRITE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SHIFT,
      ST_INS_PUT,
      ST_RD_FRONT,
      ST_RD_BACK,
      ST_RESULT
   } seq_state_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [FIELD_W-1:0]  value;
      logic [OFFSET_W-1:0] offset;
   } req_item_type;

   typedef struct packed {
      status_type          status;
      logic [FIELD_W-1:0]  read_data;
      logic [COUNT_W-1:0]  element_count;
      logic [FIELD_W-1:0]  front_value;
      logic [FIELD_W-1:0]  back_value;
   } rsp_item_type;

   typedef struct packed {
      logic                wr;
      logic [COUNT_W-1:0]  capacity;
   } cfg_wr_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctrl_type;

endpackage

### design/rdq_if.sv
// Valid/ready channel interfaces for the deque's request and response beats.
interface rdq_req_if;
   logic                          valid;
   logic                          ready;
   logic [rdq_pkg::MODE_W-1:0]    mode;
   logic [rdq_pkg::FIELD_W-1:0]   value;
   logic [rdq_pkg::OFFSET_W-1:0]  offset;

   modport source (output valid, mode, value, offset, input ready);
   modport sink   (input valid, mode, value, offset, output ready);
endinterface

interface rdq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rdq_pkg::STATUS_W-1:0]  status;
   logic [rdq_pkg::FIELD_W-1:0]   read_data;
   logic [rdq_pkg::COUNT_W-1:0]   element_count;
   logic [rdq_pkg::FIELD_W-1:0]   front_value;
   logic [rdq_pkg::FIELD_W-1:0]   back_value;

   modport source (output valid, status, read_data, element_count, front_value, back_value,
                   input ready);
   modport sink   (input valid, status, read_data, element_count, front_value, back_value,
                   output ready);
endinterface

### design/rdq_wrap_unit.sv
// Shared modular adder: (base + k) mod cap, valid while base < cap and k <= cap.
module rdq_wrap_unit #(
   parameter int DEPTH = 256
) (
   input  logic [$clog2(DEPTH)-1:0]     base,
   input  logic [rdq_pkg::COUNT_W-1:0]  k,
   input  logic [rdq_pkg::COUNT_W-1:0]  cap,
   output logic [$clog2(DEPTH)-1:0]     idx
);

   localparam int AW = $clog2(DEPTH);
   localparam int SW = ((AW > rdq_pkg::COUNT_W) ? AW : rdq_pkg::COUNT_W) + 1;

   logic [SW-1:0] sum;
   logic [SW-1:0] cap_w;
   logic [SW-1:0] diff;

   assign sum   = SW'(base) + SW'(k);
   assign cap_w = SW'(cap);
   assign diff  = sum - cap_w;
   assign idx   = (sum >= cap_w) ? diff[AW-1:0] : sum[AW-1:0];

endmodule

### design/rdq_slot_ram.sv
// Slot store: one write port and one read port with registered read data.
module rdq_slot_ram #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                        clock,
   input  rdq_pkg::ram_ctrl_type       ctrl,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [DATA_WIDTH-1:0]       wr_data,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [DATA_WIDTH-1:0]       rd_q
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_q <= mem[rd_addr];
      end
   end

endmodule

### design/rdq_seq.sv
// Sequencer: ring pointers, per-operation steps, tail shift and result assembly.
module rdq_seq #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  rdq_pkg::req_item_type       req_item,
   input  rdq_pkg::cfg_wr_type         cfg_wr,
   input  logic                        out_free,
   output logic                        result_load,
   output rdq_pkg::rsp_item_type       result
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = rdq_pkg::COUNT_W;
   localparam int FW   = rdq_pkg::FIELD_W;
   localparam int WMAX = (DATA_WIDTH > FW) ? DATA_WIDTH : FW;
   localparam int CAP_RESET = (DEPTH < rdq_pkg::CAPACITY_RESET) ? DEPTH
                                                                 : rdq_pkg::CAPACITY_RESET;

   rdq_pkg::seq_state_type state_ff, state_in;
   rdq_pkg::status_type    status_ff, status_in;

   logic [AW-1:0]              front_ff, front_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              cap_ff, cap_in;
   logic [rdq_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [DATA_WIDTH-1:0]      value_ff, value_in;
   logic [CW-1:0]              offset_ff, offset_in;
   logic                       rd_flag_ff, rd_flag_in;
   logic [FW-1:0]              rd_data_ff, rd_data_in;
   logic [FW-1:0]              front_val_ff, front_val_in;
   logic [CW-1:0]              k_ff, k_in;
   logic [AW-1:0]              dst_ff, dst_in;
   logic [AW-1:0]              wdst_ff, wdst_in;
   logic                       pend_ff, pend_in;
   logic [AW-1:0]              clr_addr_ff, clr_addr_in;

   logic [CW-1:0]              wrap_k;
   logic [AW-1:0]              wrap_idx;
   rdq_pkg::ram_ctrl_type      ram_ctrl;
   logic [AW-1:0]              wr_addr;
   logic [DATA_WIDTH-1:0]      wr_data;
   logic [AW-1:0]              rd_addr;
   logic [DATA_WIDTH-1:0]      rd_q;
   logic [WMAX-1:0]            value_wide;
   logic [WMAX-1:0]            rd_wide;
   logic [FW-1:0]              rd_field;
   logic                       full;
   logic                       put_back;
   logic                       put_front;
   logic                       ins_mid;

   rdq_wrap_unit #(.DEPTH(DEPTH)) u_wrap (
      .base (front_ff),
      .k    (wrap_k),
      .cap  (cap_ff),
      .idx  (wrap_idx)
   );

   rdq_slot_ram #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_ram (
      .clock   (clock),
      .ctrl    (ram_ctrl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_q    (rd_q)
   );

   assign value_wide = WMAX'(req_item.value);
   assign rd_wide    = WMAX'(rd_q);
   assign rd_field   = rd_wide[FW-1:0];
   assign full       = (count_ff == cap_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= rdq_pkg::ST_CLEAR;
         front_ff    <= '0;
         count_ff    <= '0;
         cap_ff      <= CW'(CAP_RESET);
         pend_ff     <= 1'b0;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         front_ff    <= front_in;
         count_ff    <= count_in;
         cap_ff      <= cap_in;
         pend_ff     <= pend_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      mode_ff      <= mode_in;
      value_ff     <= value_in;
      offset_ff    <= offset_in;
      rd_flag_ff   <= rd_flag_in;
      rd_data_ff   <= rd_data_in;
      front_val_ff <= front_val_in;
      k_ff         <= k_in;
      dst_ff       <= dst_in;
      wdst_ff      <= wdst_in;
   end

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      mode_in      = mode_ff;
      value_in     = value_ff;
      offset_in    = offset_ff;
      rd_flag_in   = rd_flag_ff;
      rd_data_in   = rd_data_ff;
      front_val_in = front_val_ff;
      k_in         = k_ff;
      dst_in       = dst_ff;
      wdst_in      = wdst_ff;
      pend_in      = pend_ff;
      clr_addr_in  = clr_addr_ff;
      wrap_k       = '0;
      ram_ctrl     = '0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr      = '0;
      req_ready    = 1'b0;
      result_load  = 1'b0;
      put_back     = 1'b0;
      put_front    = 1'b0;
      ins_mid      = 1'b0;

      unique case (state_ff)
         rdq_pkg::ST_CLEAR: begin
            ram_ctrl.wr_en = 1'b1;
            wr_addr        = clr_addr_ff;
            clr_addr_in    = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = rdq_pkg::ST_IDLE;
            end
         end

         rdq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in    = req_item.mode;
               value_in   = value_wide[DATA_WIDTH-1:0];
               offset_in  = CW'(req_item.offset);
               status_in  = rdq_pkg::STATUS_OK;
               rd_flag_in = 1'b0;
               rd_data_in = '0;
               state_in   = rdq_pkg::ST_EXEC;
            end
         end

         rdq_pkg::ST_EXEC: begin
            state_in = rdq_pkg::ST_RD_FRONT;
            unique case (mode_ff)
               rdq_pkg::MODE_PUSH_BACK:  put_back  = 1'b1;
               rdq_pkg::MODE_PUSH_FRONT: put_front = 1'b1;
               rdq_pkg::MODE_POP_FRONT: begin
                  if (count_ff == '0) begin
                     status_in = rdq_pkg::STATUS_EMPTY;
                  end else begin
                     wrap_k   = CW'(1);
                     front_in = wrap_idx;
                     count_in = count_ff - 1'b1;
                  end
               end
               rdq_pkg::MODE_POP_BACK: begin
                  if (count_ff == '0) begin
                     status_in = rdq_pkg::STATUS_EMPTY;
                  end else begin
                     count_in = count_ff - 1'b1;
                  end
               end
               rdq_pkg::MODE_READ_AT: begin
                  if (offset_ff >= count_ff) begin
                     status_in = rdq_pkg::STATUS_RANGE;
                  end else begin
                     wrap_k         = offset_ff;
                     ram_ctrl.rd_en = 1'b1;
                     rd_addr        = wrap_idx;
                     rd_flag_in     = 1'b1;
                  end
               end
               rdq_pkg::MODE_INSERT_AT: begin
                  if (offset_ff > count_ff) begin
                     status_in = rdq_pkg::STATUS_RANGE;
                  end else if (offset_ff == '0) begin
                     put_front = 1'b1;
                  end else if (offset_ff == count_ff) begin
                     put_back = 1'b1;
                  end else begin
                     ins_mid = 1'b1;
                  end
               end
               rdq_pkg::MODE_CLEAR: begin
                  front_in = '0;
                  count_in = '0;
               end
               default: ;
            endcase

            if (put_back) begin
               ram_ctrl.wr_en = 1'b1;
               wr_data        = value_ff;
               if (full) begin
                  // The oldest slot is the one at front; overwrite it and move on.
                  wr_addr   = front_ff;
                  wrap_k    = CW'(1);
                  front_in  = wrap_idx;
                  status_in = rdq_pkg::STATUS_OVERWRITE;
               end else begin
                  wrap_k   = count_ff;
                  wr_addr  = wrap_idx;
                  count_in = count_ff + 1'b1;
               end
            end

            if (put_front) begin
               wrap_k         = cap_ff - 1'b1;
               front_in       = wrap_idx;
               ram_ctrl.wr_en = 1'b1;
               wr_addr        = wrap_idx;
               wr_data        = value_ff;
               if (full) begin
                  status_in = rdq_pkg::STATUS_OVERWRITE;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end

            if (ins_mid) begin
               wrap_k   = count_ff;
               dst_in   = wrap_idx;
               k_in     = count_ff - 1'b1;
               pend_in  = 1'b0;
               state_in = rdq_pkg::ST_SHIFT;
            end
         end

         rdq_pkg::ST_SHIFT: begin
            // Read slot k while last cycle's read, from slot k+1, lands at slot k+2.
            wrap_k = k_ff;
            if (pend_ff) begin
               ram_ctrl.wr_en = 1'b1;
               wr_addr        = wdst_ff;
               wr_data        = rd_q;
            end
            if (k_ff >= offset_ff) begin
               ram_ctrl.rd_en = 1'b1;
               rd_addr        = wrap_idx;
               wdst_in        = dst_ff;
               dst_in         = wrap_idx;
               pend_in        = 1'b1;
               k_in           = k_ff - 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = rdq_pkg::ST_INS_PUT;
            end
         end

         rdq_pkg::ST_INS_PUT: begin
            ram_ctrl.wr_en = 1'b1;
            wr_addr        = dst_ff;
            wr_data        = value_ff;
            if (full) begin
               wrap_k    = CW'(1);
               front_in  = wrap_idx;
               status_in = rdq_pkg::STATUS_OVERWRITE;
            end else begin
               count_in = count_ff + 1'b1;
            end
            state_in = rdq_pkg::ST_RD_FRONT;
         end

         rdq_pkg::ST_RD_FRONT: begin
            if (rd_flag_ff) begin
               rd_data_in = rd_field;
            end
            ram_ctrl.rd_en = 1'b1;
            rd_addr        = front_ff;
            state_in       = rdq_pkg::ST_RD_BACK;
         end

         rdq_pkg::ST_RD_BACK: begin
            front_val_in   = rd_field;
            wrap_k         = (count_ff == '0) ? '0 : (count_ff - 1'b1);
            ram_ctrl.rd_en = 1'b1;
            rd_addr        = wrap_idx;
            state_in       = rdq_pkg::ST_RESULT;
         end

         rdq_pkg::ST_RESULT: begin
            if (out_free) begin
               result_load = 1'b1;
               state_in    = rdq_pkg::ST_IDLE;
            end
         end

         default: state_in = rdq_pkg::ST_IDLE;
      endcase

      // Write capacity only when idle (unchecked); it clamps and empties the deque.
      if (cfg_wr.wr) begin
         if (cfg_wr.capacity == '0) begin
            cap_in = CW'(1);
         end else if (32'(cfg_wr.capacity) > 32'(DEPTH)) begin
            cap_in = CW'(DEPTH);
         end else begin
            cap_in = cfg_wr.capacity;
         end
         front_in = '0;
         count_in = '0;
      end
   end

   always_comb begin
      result.status        = status_ff;
      result.read_data     = rd_data_ff;
      result.element_count = count_ff;
      result.front_value   = (count_ff == '0) ? '0 : front_val_ff;
      result.back_value    = (count_ff == '0) ? '0 : rd_field;
   end

endmodule

### design/ring_deque_with_overwrite_top.sv
// Top level of the ring deque with overwrite: channels, register port and response register.
//
// Requests arrive on req_chan as valid/ready beats carrying mode, value and offset; each
// accepted beat yields exactly one response beat on rsp_chan with status, read data, the
// element count and the front and back elements after the operation.
// The capacity register (byte address 0) is written over the APB-style csr_ port; a write
// clamps the value to 1..DEPTH and empties the deque. Slot contents are kept.
// Each accepted request steps through the sequencer's execute, front read, back read and
// result states. An insert in the middle first passes the shift state, where the tail
// moves one slot per cycle through the slot store's read and write ports, and then the
// insert state that writes the new element. The sequencer handles one item at a time and
// takes no new request before the last has left the result state; the slot store's single
// read port sets the pace. After reset the slot store is swept to zero, one slot per cycle,
// so req_chan.ready stays low until the sweep ends; register writes are taken during it.
// A finished response sits in an output register. While the receiver stalls, the next
// request is still accepted and worked on, and it waits at the end of its work until the
// output register frees up.
module ring_deque_with_overwrite_top #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   rdq_req_if.sink                           req_chan,
   rdq_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rdq_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rdq_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rdq_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   rdq_pkg::req_item_type         req_item;
   rdq_pkg::rsp_item_type         result;
   rdq_pkg::rsp_item_type         rsp_data_ff, rsp_data_in;
   rdq_pkg::cfg_wr_type           cfg_wr;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rdq_pkg::COUNT_W-1:0]   capacity_ff, capacity_in;
   logic                          result_load;
   logic                          out_free;
   logic                          cap_hit;

   // The register port never waits.
   assign csr_pready = 1'b1;
   assign cap_hit    = (csr_paddr == rdq_pkg::CSR_CAPACITY_ADDR);

   always_comb begin
      cfg_wr.wr       = csr_psel && csr_penable && csr_pwrite && cap_hit;
      cfg_wr.capacity = csr_pwdata[rdq_pkg::COUNT_W-1:0];
      capacity_in     = cfg_wr.wr ? cfg_wr.capacity : capacity_ff;
      csr_prdata      = cap_hit ? rdq_pkg::CSR_DATA_W'(capacity_ff) : '0;
   end

   // The raw register value reads back unclamped; the sequencer keeps the clamped copy.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= rdq_pkg::COUNT_W'(rdq_pkg::CAPACITY_RESET);
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      req_item.mode   = req_chan.mode;
      req_item.value  = req_chan.value;
      req_item.offset = req_chan.offset;
   end

   // The output register is free when empty or when its beat leaves this cycle.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   rdq_seq #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_item    (req_item),
      .cfg_wr      (cfg_wr),
      .out_free    (out_free),
      .result_load (result_load),
      .result      (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_data_ff.status;
   assign rsp_chan.read_data     = rsp_data_ff.read_data;
   assign rsp_chan.element_count = rsp_data_ff.element_count;
   assign rsp_chan.front_value   = rsp_data_ff.front_value;
   assign rsp_chan.back_value    = rsp_data_ff.back_value;

endmodule

### design/rdq_checker.sv
// Port-level checks on the ring deque's request and response beats, bound to the top level.
module rdq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [rdq_pkg::STATUS_W-1:0]      status,
   input logic [rdq_pkg::FIELD_W-1:0]       read_data,
   input logic [rdq_pkg::COUNT_W-1:0]       element_count,
   input logic [rdq_pkg::FIELD_W-1:0]       front_value,
   input logic [rdq_pkg::FIELD_W-1:0]       back_value
);

   // A stalled response beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(read_data)
         && $stable(element_count) && $stable(front_value) && $stable(back_value))
      else $error("response beat changed while stalled");

   // One request at a time: the sequencer drops ready right after taking a beat.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while the previous one is still in work");

   // An empty-pop error leaves an empty deque behind.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == rdq_pkg::STATUS_EMPTY |-> element_count == '0)
      else $error("empty status with a nonzero element count");

   // Read data only comes from a successful read at an offset.
   a_read_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && read_data != '0 |-> status == rdq_pkg::STATUS_OK)
      else $error("read data present on a failed or non-read operation");

   // An empty deque reports zero front and back elements.
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && element_count == '0 |-> front_value == '0 && back_value == '0)
      else $error("front or back value nonzero on an empty deque");

endmodule

bind ring_deque_with_overwrite_top rdq_checker u_rdq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .status        (rsp_chan.status),
   .read_data     (rsp_chan.read_data),
   .element_count (rsp_chan.element_count),
   .front_value   (rsp_chan.front_value),
   .back_value    (rsp_chan.back_value)
);
